// File: hw/rtl/sm3_block_hash_top_defines.svh
// Assertion helpers for the SM3 block hash engine.
// Each macro expects clk and rst_n in scope.
`ifndef SM3_BLOCK_HASH_TOP_DEFINES_SVH
`define SM3_BLOCK_HASH_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define SM3BH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define SM3BH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/sm3_bh_pkg.sv
package sm3_bh_pkg;

  typedef logic [31:0] word_t;
  // Working registers / chaining value; element 0 is register A
  typedef logic [7:0][31:0] regs_t;

  localparam int BlockWords  = 16;
  localparam int NumRounds   = 64;
  localparam int XorRounds   = 16;
  localparam int DigestWords = 8;

  localparam word_t T_LOW  = 32'h79CC4519;
  localparam word_t T_HIGH = 32'h7A879D8A;

  localparam regs_t SM3_IV = {
    32'hB0FB0E4E, 32'hE38DEE4D, 32'h163138AA, 32'hA96F30BC,
    32'hDA8A0600, 32'h172442D7, 32'h4914B2B9, 32'h7380166F
  };

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_ROUND,
    ST_EMIT
  } fsm_t;

  typedef struct packed {
    logic shift;
    logic load;
  } sched_ctl_t;

  function automatic word_t rotl(input word_t x, input logic [4:0] n);
    logic [63:0] tmp;
    tmp = {x, x} << n;
    return tmp[63:32];
  endfunction

  function automatic word_t perm0(input word_t x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic word_t perm1(input word_t x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

endpackage

// File: hw/rtl/sm3_block_hash_top.sv
// SM3 compression engine over pre-padded 512-bit blocks.
// Input: present one 32-bit message word per transfer on in_message_word,
//   word 0 of a block first, with start high; a transfer happens on a
//   rising edge where start is high and busy is low. in_first_block and
//   in_last_block are sampled only with the sixteenth word of a block:
//   first reloads the standard IV, last requests the digest.
// The first fifteen words of a block fill the schedule window. The sixteenth
//   word starts 64 compression rounds, one per cycle through a single shared
//   round unit, with the message schedule expanded on the fly in a 16-word
//   sliding window; busy stays high throughout.
// After a last block the eight digest words follow, A first, one per cycle
//   with out_valid high, out_word_index 0..7 and out_last_word on the
//   eighth; busy stays high meanwhile. The receiver cannot stall them.
// The first digest word is driven once the last round of a last block has
//   been folded into the chaining value.
// Words of a new block are not taken while a compression or digest is running.
// Without a first flag the chain continues from the current value.
// Reset (rst_n low, synchronous) returns the word counter to zero, the
//   chaining value to the IV and drops any block in progress.
`include "sm3_block_hash_top_defines.svh"

module sm3_block_hash_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_message_word,
  input  logic        in_first_block,
  input  logic        in_last_block,
  output logic        out_valid,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);
  import sm3_bh_pkg::*;

  localparam logic [3:0] LastWord  = 4'(BlockWords - 1);
  localparam logic [5:0] LastRound = 6'(NumRounds - 1);
  localparam logic [2:0] LastIdx   = 3'(DigestWords - 1);

  fsm_t       state_r, state_nxt;
  logic [3:0] word_cnt_r;
  logic [5:0] round_r;
  logic [2:0] idx_r;
  logic       last_r;
  regs_t      work_r;
  regs_t      chain_r;
  regs_t      round_out;
  word_t      w, wp;
  sched_ctl_t sched_ctl;
  logic       accept;
  logic       block_done;

  assign accept     = start && (state_r == ST_LOAD);
  assign block_done = accept && (word_cnt_r == LastWord);

  sm3_bh_sched u_sched (
    .clk    (clk),
    .ctl_i  (sched_ctl),
    .word_i (in_message_word),
    .w_o    (w),
    .wp_o   (wp)
  );

  sm3_bh_round u_round (
    .work_i  (work_r),
    .w_i     (w),
    .wp_i    (wp),
    .round_i (round_r),
    .work_o  (round_out)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (block_done) state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        if (round_r == LastRound) state_nxt = last_r ? ST_EMIT : ST_LOAD;
      end
      ST_EMIT: begin
        if (idx_r == LastIdx) state_nxt = ST_LOAD;
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // Outputs and datapath controls
  always_comb begin
    busy            = (state_r != ST_LOAD);
    out_valid       = (state_r == ST_EMIT);
    out_digest_word = chain_r[idx_r];
    out_word_index  = idx_r;
    out_last_word   = out_valid && (idx_r == LastIdx);
    sched_ctl.load  = accept;
    sched_ctl.shift = accept || (state_r == ST_ROUND);
  end

  // Control state and chaining value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_LOAD;
      word_cnt_r <= '0;
      round_r    <= '0;
      idx_r      <= '0;
      last_r     <= 1'b0;
      chain_r    <= SM3_IV;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        word_cnt_r <= word_cnt_r + 4'd1;
      end
      if (block_done) begin
        last_r <= in_last_block;
        if (in_first_block) chain_r <= SM3_IV;
      end
      if (state_r == ST_ROUND) begin
        // advance the round; fold the result into the chain after the last one
        round_r <= round_r + 6'd1;
        if (round_r == LastRound) chain_r <= chain_r ^ round_out;
      end
      if (state_r == ST_EMIT) begin
        idx_r <= idx_r + 3'd1;
      end
    end
  end

  // Working registers A..H: hold between blocks, load at block start
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      work_r <= '0;
    end else if (block_done) begin
      work_r <= in_first_block ? SM3_IV : chain_r;
    end else if (state_r == ST_ROUND) begin
      work_r <= round_out;
    end
  end

  `SM3BH_ASSERT_NOW(a_valid_busy, out_valid, busy, "digest transfer while idle")
  `SM3BH_ASSERT_NEXT(a_block_start, start && !busy && (word_cnt_r == LastWord),
                     busy && (round_r == 6'd0), "compression did not start at round zero")
  `SM3BH_ASSERT_NEXT(a_emit_burst, out_valid && !out_last_word, out_valid,
                     "digest burst broken before its final word")
  `SM3BH_ASSERT_NEXT(a_no_emit_mid, (state_r == ST_ROUND) && (round_r == LastRound) && !last_r,
                     !busy && !out_valid, "block without last flag did not return to load")

endmodule

// File: hw/rtl/sm3_bh_sched.sv
module sm3_bh_sched (
  input  logic                    clk,
  input  sm3_bh_pkg::sched_ctl_t  ctl_i,
  input  sm3_bh_pkg::word_t       word_i,
  output sm3_bh_pkg::word_t       w_o,
  output sm3_bh_pkg::word_t       wp_o
);
  import sm3_bh_pkg::*;

  // Sliding window: entry k holds W[j+k] during round j
  word_t win_r [BlockWords];
  word_t expand;

  always_comb begin
    expand = perm1(win_r[0] ^ win_r[7] ^ rotl(win_r[13], 5'd15))
             ^ rotl(win_r[3], 5'd7) ^ win_r[10];
  end

  always_ff @(posedge clk) begin
    if (ctl_i.shift) begin
      for (int k = 0; k < BlockWords - 1; k++) begin
        win_r[k] <= win_r[k + 1];
      end
      win_r[BlockWords - 1] <= ctl_i.load ? word_i : expand;
    end
  end

  assign w_o  = win_r[0];
  assign wp_o = win_r[0] ^ win_r[4];

endmodule

// File: hw/rtl/sm3_bh_round.sv
module sm3_bh_round (
  input  sm3_bh_pkg::regs_t  work_i,
  input  sm3_bh_pkg::word_t  w_i,
  input  sm3_bh_pkg::word_t  wp_i,
  input  logic [5:0]         round_i,
  output sm3_bh_pkg::regs_t  work_o
);
  import sm3_bh_pkg::*;

  word_t a, b, c, d, e, f, g, h;
  word_t a12, tj, ss1, ss2, ff, gg, tt1, tt2;
  logic  xor_phase;

  always_comb begin
    {h, g, f, e, d, c, b, a} = work_i;
    xor_phase = (round_i < 6'(XorRounds));
    tj  = xor_phase ? T_LOW : T_HIGH;
    a12 = rotl(a, 5'd12);
    ss1 = rotl(a12 + e + rotl(tj, round_i[4:0]), 5'd7);
    ss2 = ss1 ^ a12;
    if (xor_phase) begin
      ff = a ^ b ^ c;
      gg = e ^ f ^ g;
    end else begin
      ff = (a & b) | (a & c) | (b & c);
      gg = (e & f) | (~e & g);
    end
    tt1 = ff + d + ss2 + wp_i;
    tt2 = gg + h + ss1 + w_i;
    work_o = {g, rotl(f, 5'd19), e, perm0(tt2), c, rotl(b, 5'd9), a, tt1};
  end

endmodule

// File: dv/sm3_digest_check_pkg.sv
`timescale 1ns / 100ps

package sm3_digest_check_pkg;
  import sm3_bh_pkg::*;

  class sm3_digest_scoreboard;
    typedef struct {
      word_t      word;
      logic [2:0] index;
      logic       final_word;
    } digest_beat_t;

    word_t        block_buf[BlockWords];
    regs_t        chain;
    int unsigned  fill;
    digest_beat_t awaited[$];
    int unsigned  errors;

    function new();
      chain  = SM3_IV;
      fill   = 0;
      errors = 0;
    endfunction

    static function word_t rol(word_t x, int unsigned n);
      n = n % 32;
      if (n == 0) return x;
      return (x << n) | (x >> (32 - n));
    endfunction

    // Take one transferred word; on the sixteenth, compress and queue the digest if asked.
    function void note_word(word_t word, logic is_first, logic is_last);
      word_t w[68];
      word_t a, b, c, d, e, f, g, h;
      word_t x, tj, a12, ss1, ss2, ff, gg, tt1, tt2;
      digest_beat_t beat;
      block_buf[fill] = word;
      if (fill != BlockWords - 1) begin
        fill++;
        return;
      end
      fill = 0;
      if (is_first) chain = SM3_IV;

      for (int j = 0; j < 16; j++) w[j] = block_buf[j];
      for (int j = 16; j < 68; j++) begin
        x    = w[j-16] ^ w[j-9] ^ rol(w[j-3], 15);
        w[j] = x ^ rol(x, 15) ^ rol(x, 23) ^ rol(w[j-13], 7) ^ w[j-6];
      end

      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
      e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
      for (int j = 0; j < NumRounds; j++) begin
        tj  = (j < XorRounds) ? T_LOW : T_HIGH;
        a12 = rol(a, 12);
        ss1 = rol(a12 + e + rol(tj, j), 7);
        ss2 = ss1 ^ a12;
        if (j < XorRounds) begin
          ff = a ^ b ^ c;
          gg = e ^ f ^ g;
        end else begin
          ff = (a & b) | (a & c) | (b & c);
          gg = (e & f) | (~e & g);
        end
        tt1 = ff + d + ss2 + (w[j] ^ w[j+4]);
        tt2 = gg + h + ss1 + w[j];
        d = c;
        c = rol(b, 9);
        b = a;
        a = tt1;
        h = g;
        g = rol(f, 19);
        f = e;
        e = tt2 ^ rol(tt2, 9) ^ rol(tt2, 17);
      end
      chain[0] ^= a; chain[1] ^= b; chain[2] ^= c; chain[3] ^= d;
      chain[4] ^= e; chain[5] ^= f; chain[6] ^= g; chain[7] ^= h;

      if (!is_last) return;
      for (int k = 0; k < DigestWords; k++) begin
        beat.word       = chain[k];
        beat.index      = k[2:0];
        beat.final_word = (k == DigestWords - 1);
        awaited.push_back(beat);
      end
    endfunction

    function void check_digest(word_t word, logic [2:0] index, logic final_word);
      digest_beat_t beat;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected digest word %h index %0d", $time, word, index);
        errors++;
        return;
      end
      beat = awaited.pop_front();
      if (word !== beat.word) begin
        $display("%0t: digest_word expected %h actual %h", $time, beat.word, word);
        errors++;
      end
      if (index !== beat.index) begin
        $display("%0t: word_index expected %0d actual %0d", $time, beat.index, index);
        errors++;
      end
      if (final_word !== beat.final_word) begin
        $display("%0t: last_word expected %b actual %b", $time, beat.final_word, final_word);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction
  endclass

endpackage

// File: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import sm3_bh_pkg::*;
  import sm3_digest_check_pkg::*;

  // Blocks of random words per idling phase: 9 + 9 + 8 blocks, about 430 words with
  // the directed block.
  localparam int PhaseBlocks[3] = '{9, 9, 8};
  // Sender idle chance per phase, in percent.
  localparam int PhaseIdle[3]   = '{28, 65, 0};
  // A block is at most 16 words, 64 rounds and 8 digest beats, so even the slowest
  // run stays well inside this limit.
  localparam int CycleLimit     = 200000;
  // Allow for a compression still running on a block that asked for no digest.
  localparam int DrainCycles    = 100;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [31:0] in_message_word;
  logic        in_first_block;
  logic        in_last_block;
  logic        out_valid;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  sm3_digest_scoreboard digest_sb;
  int unsigned          cycle_count = 0;

  sm3_block_hash_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_message_word (in_message_word),
    .in_first_block  (in_first_block),
    .in_last_block   (in_last_block),
    .out_valid       (out_valid),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

  // 8 ns clock, first rising edge at 4 ns
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Watchdog: abandon the run if the block hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Digest beats cannot be held off, so check every strobed cycle at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_valid)
      digest_sb.check_digest(out_digest_word, out_word_index, out_last_word);
  end

  // Present one word and hold it until the transfer. With the given chance, drop start
  // first, with junk on the data port that must be ignored.
  task automatic send_message_word(input word_t word, input logic is_first,
                                   input logic is_last, input int unsigned idle_pct);
    int unsigned gap;
    gap = ($urandom_range(99) < idle_pct) ? $urandom_range(8, 1) : 0;
    @(negedge clk);
    if (gap != 0) begin
      start           <= 1'b0;
      in_message_word <= $urandom;
      repeat (gap) @(negedge clk);
    end
    start           <= 1'b1;
    in_message_word <= word;
    in_first_block  <= is_first;
    in_last_block   <= is_last;
    // Transfer happens at the first rising edge with busy low
    do @(posedge clk); while (busy !== 1'b0);
    digest_sb.note_word(word, is_first, is_last);
  endtask

  initial begin
    word_t       word;
    logic        is_first;
    logic        is_last;
    int unsigned idle_pct;

    digest_sb       = new();
    rst_n           = 1'b0;
    start           = 1'b0;
    in_message_word = '0;
    in_first_block  = 1'b0;
    in_last_block   = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed block straight after reset: alternate all-zero and all-one words, set
    // both flags on the first fifteen words (they must be ignored) and leave the first
    // flag clear on the sixteenth, so the chain must start from the reset IV.
    for (int i = 0; i < BlockWords; i++) begin
      word = (i % 2 == 0) ? 32'h0000_0000 : 32'hFFFF_FFFF;
      if (i == BlockWords - 1)
        send_message_word(word, 1'b0, 1'b1, 0);
      else
        send_message_word(word, 1'b1, 1'b1, 0);
    end

    // Random blocks. Roughly half reload the IV and half ask for a digest, so chains
    // run across several blocks and also continue on from a previous digest.
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = PhaseIdle[phase];
      for (int blk = 0; blk < PhaseBlocks[phase]; blk++) begin
        for (int i = 0; i < BlockWords; i++) begin
          case ($urandom_range(9))
            0:       word = 32'h0000_0000;
            1:       word = 32'hFFFF_FFFF;
            2:       word = 32'h1 << $urandom_range(31);
            3:       word = ~(32'h1 << $urandom_range(31));
            default: word = $urandom;
          endcase
          // Flags count only on the sixteenth word; elsewhere drive noise
          is_first = 1'($urandom_range(1));
          is_last  = 1'($urandom_range(1));
          send_message_word(word, is_first, is_last, idle_pct);
        end
      end
    end

    @(negedge clk);
    start <= 1'b0;

    // Drain: wait for the outstanding digests, then a little longer for stray beats
    while (digest_sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (digest_sb.errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
